FILE: sv/ira_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ira_pkg
// Shared types and constants of the index range allocator.
// ----------------------------------------------------------------------------
package ira_pkg;

	localparam int MAX_RANGES = 64;
	localparam int AW = $clog2(MAX_RANGES);
	localparam int CW = $clog2(MAX_RANGES + 1);

	typedef enum logic [1:0] {
		OP_MARK  = 2'd0,
		OP_QUERY = 2'd1,
		OP_ALLOC = 2'd2,
		OP_COUNT = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_NONE = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] index;
		logic        want_used;
	} in_word_t;

	typedef struct packed {
		logic [31:0] new_index;
		logic        matches_res;
		logic [32:0] index_count;
		logic [1:0]  status;
	} out_word_t;

endpackage
`default_nettype wire

FILE: sv/index_range_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// index_range_allocator
// Sorted table of used index ranges with mark, query, allocate and count.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | in_word_t
// out     | out | out_valid/out_stall| out_word_t
//
// One word at a time. A word scans the range memory one entry after another up
// to the decision; an insert or remove then shifts the tail one entry at a time.
// Reset clears the range count and the control state; the memory needs no clearing.
// in_stall is high while a word is in work or its result waits in out.
// ----------------------------------------------------------------------------
module index_range_allocator
	import ira_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_word_t  in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_word_t      out_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_SCAN, S_DEC, S_WR, S_SHR, S_SHRW, S_SHL, S_SHLW, S_FIN
	} state_t;

	logic [31:0] lo_mem [MAX_RANGES];
	logic [31:0] hi_mem [MAX_RANGES];
	logic [31:0] lo_rd, hi_rd;
	logic [AW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wlo, whi;

	always_ff @(posedge clk) begin
		if (we) begin
			lo_mem[waddr] <= wlo;
			hi_mem[waddr] <= whi;
		end
		lo_rd <= lo_mem[raddr];
		hi_rd <= hi_mem[raddr];
	end

	state_t      state_q;
	in_word_t    req_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ptr_q;     // scan position
	logic [CW-1:0] p_q;       // first entry with low > index
	logic [31:0] plo_q, phi_q; // entry p-1
	logic [31:0] nlo_q, nhi_q; // entry p
	logic          pv_q, nv_q;
	logic [32:0] sum_q;
	logic [CW-1:0] sh_q;      // shift cursor
	logic [CW-1:0] dst_q;     // insert/drop position
	logic [31:0] ilo_q, ihi_q;
	logic          mrg_q;     // left shift merges into dst
	logic [31:0] lo0_q, hi0_q; // entry 0 and 1 for allocate
	logic [31:0] lo1_q;
	logic          we_q;
	logic [AW-1:0] waddr_q;
	logic [31:0] wlo_q, whi_q;

	assign we = we_q;
	assign waddr = waddr_q;
	assign wlo = wlo_q;
	assign whi = whi_q;
	assign in_stall = (state_q != S_IDLE) || out_valid;

	always_comb begin
		raddr = ptr_q[AW-1:0];
		if (state_q == S_SHR)
			raddr = AW'(sh_q - CW'(1));
		else if (state_q == S_SHL)
			raddr = sh_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
			we_q      <= 1'b0;
		end else begin
			we_q <= 1'b0;
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			unique case (state_q)
			S_IDLE: begin
				if (in_valid && !in_stall) begin
					req_q <= in_data;
					ptr_q <= '0;
					p_q   <= '0;
					pv_q  <= 1'b0;
					nv_q  <= 1'b0;
					sum_q <= '0;
					out_data <= '0;
					state_q <= S_RD;
				end
			end
			S_RD: begin
				state_q <= (ptr_q == cnt_q) ? S_DEC : S_SCAN;
			end
			S_SCAN: begin
				if (ptr_q == '0) begin
					lo0_q <= lo_rd;
					hi0_q <= hi_rd;
				end
				if (ptr_q == CW'(1))
					lo1_q <= lo_rd;
				sum_q <= sum_q + {1'b0, hi_rd - lo_rd} + 33'd1;
				if (!nv_q && (lo_rd > req_q.index)) begin
					nv_q  <= 1'b1;
					nlo_q <= lo_rd;
					nhi_q <= hi_rd;
				end else if (!nv_q) begin
					pv_q  <= 1'b1;
					plo_q <= lo_rd;
					phi_q <= hi_rd;
					p_q   <= ptr_q + CW'(1);
				end
				ptr_q <= ptr_q + CW'(1);
				state_q <= S_RD;
			end
			S_DEC: begin
				state_q <= S_FIN;
				unique case (op_t'(req_q.op))
				OP_QUERY: begin
					out_data.matches_res <=
						((pv_q && phi_q >= req_q.index) == req_q.want_used);
				end
				OP_COUNT: begin
					out_data.index_count <= req_q.want_used ? sum_q :
						(33'h1_0000_0000 - sum_q);
				end
				OP_ALLOC: begin
					if (cnt_q == '0) begin
						out_data.new_index <= 32'd1;
						dst_q <= '0; ilo_q <= 32'd1; ihi_q <= 32'd1;
						sh_q <= cnt_q; state_q <= S_SHR;
					end else if (lo0_q > 32'd1) begin
						out_data.new_index <= lo0_q - 32'd1;
						we_q <= 1'b1; waddr_q <= '0;
						wlo_q <= lo0_q - 32'd1; whi_q <= hi0_q;
					end else if (hi0_q == 32'hFFFF_FFFF) begin
						out_data.status <= ST_NONE;
					end else begin
						out_data.new_index <= hi0_q + 32'd1;
						if (cnt_q > CW'(1) && lo1_q == hi0_q + 32'd2) begin
							sh_q <= CW'(1); dst_q <= '0;
							ilo_q <= lo0_q; mrg_q <= 1'b1; state_q <= S_SHL;
						end else begin
							we_q <= 1'b1; waddr_q <= '0;
							wlo_q <= lo0_q; whi_q <= hi0_q + 32'd1;
						end
					end
				end
				default: begin
					if (req_q.want_used) begin
						if (pv_q && phi_q >= req_q.index) begin
						end else if (pv_q && phi_q + 32'd1 == req_q.index &&
								nv_q && req_q.index + 32'd1 == nlo_q) begin
							sh_q <= p_q; dst_q <= p_q - CW'(1);
							ilo_q <= plo_q; mrg_q <= 1'b1; state_q <= S_SHL;
						end else if (pv_q && phi_q + 32'd1 == req_q.index) begin
							we_q <= 1'b1; waddr_q <= AW'(p_q - CW'(1));
							wlo_q <= plo_q; whi_q <= req_q.index;
						end else if (nv_q && req_q.index + 32'd1 == nlo_q) begin
							we_q <= 1'b1; waddr_q <= p_q[AW-1:0];
							wlo_q <= req_q.index; whi_q <= nhi_q;
						end else if (cnt_q >= CW'(MAX_RANGES)) begin
							out_data.status <= ST_FULL;
						end else begin
							dst_q <= p_q; ilo_q <= req_q.index;
							ihi_q <= req_q.index;
							sh_q <= cnt_q; state_q <= S_SHR;
						end
					end else if (pv_q && phi_q >= req_q.index) begin
						if (plo_q == req_q.index && phi_q == req_q.index) begin
							sh_q <= p_q; dst_q <= p_q - CW'(1);
							mrg_q <= 1'b0; state_q <= S_SHL;
						end else if (plo_q == req_q.index) begin
							we_q <= 1'b1; waddr_q <= AW'(p_q - CW'(1));
							wlo_q <= req_q.index + 32'd1; whi_q <= phi_q;
						end else if (phi_q == req_q.index) begin
							we_q <= 1'b1; waddr_q <= AW'(p_q - CW'(1));
							wlo_q <= plo_q; whi_q <= req_q.index - 32'd1;
						end else if (cnt_q >= CW'(MAX_RANGES)) begin
							out_data.status <= ST_FULL;
						end else begin
							we_q <= 1'b1; waddr_q <= AW'(p_q - CW'(1));
							wlo_q <= plo_q; whi_q <= req_q.index - 32'd1;
							dst_q <= p_q; ilo_q <= req_q.index + 32'd1;
							ihi_q <= phi_q;
							sh_q <= cnt_q; state_q <= S_SHR;
						end
					end
				end
				endcase
			end
			// insert: move entries [dst, cnt) up by one, top first
			S_SHR: begin
				if (sh_q == dst_q) begin
					we_q <= 1'b1; waddr_q <= dst_q[AW-1:0];
					wlo_q <= ilo_q; whi_q <= ihi_q;
					cnt_q <= cnt_q + CW'(1);
					state_q <= S_WR;
				end else begin
					sh_q <= sh_q - CW'(1);
					state_q <= S_SHRW;
				end
			end
			S_SHRW: begin
				we_q <= 1'b1; waddr_q <= AW'(sh_q + CW'(1));
				wlo_q <= lo_rd; whi_q <= hi_rd;
				state_q <= S_SHR;
			end
			// drop: entries above dst move down; a merge keeps ilo as dst low
			S_SHL: begin
				if (sh_q == cnt_q) begin
					cnt_q <= cnt_q - CW'(1);
					state_q <= S_WR;
				end else begin
					state_q <= S_SHLW;
				end
			end
			S_SHLW: begin
				we_q <= 1'b1; waddr_q <= AW'(sh_q - CW'(1));
				whi_q <= hi_rd;
				wlo_q <= (sh_q - CW'(1) == dst_q && mrg_q) ? ilo_q : lo_rd;
				sh_q <= sh_q + CW'(1);
				state_q <= S_SHL;
			end
			S_WR: begin
				state_q <= S_FIN;
			end
			S_FIN: begin
				out_valid <= 1'b1;
				state_q <= S_IDLE;
			end
			default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_RANGES)) else $error("range count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("accept while busy");

endmodule
`default_nettype wire

FILE: tb/sv/index_range_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// index_range_allocator_test
// Drives mark, query, allocate and count words into the allocator, predicts
// each result from a private copy of the range table and compares every
// output word field by field, with random bursts on the input and stalls on
// the output.
// ----------------------------------------------------------------------------
module index_range_allocator_test
	import ira_pkg::*;
;

class range_scoreboard;
	bit [31:0] lo_tab[MAX_RANGES];
	bit [31:0] hi_tab[MAX_RANGES];
	int n_ranges;
	out_word_t pending[$];
	int errors;
	int checked;

	function new();
		n_ranges = 0;
		errors = 0;
		checked = 0;
	endfunction

	function void insert_at(int pos, bit [31:0] lo, bit [31:0] hi);
		for (int i = n_ranges; i > pos; i--) begin
			lo_tab[i] = lo_tab[i-1];
			hi_tab[i] = hi_tab[i-1];
		end
		lo_tab[pos] = lo;
		hi_tab[pos] = hi;
		n_ranges++;
	endfunction

	function void remove_at(int pos);
		for (int i = pos; i < n_ranges - 1; i++) begin
			lo_tab[i] = lo_tab[i+1];
			hi_tab[i] = hi_tab[i+1];
		end
		n_ranges--;
	endfunction

	function int first_above(bit [31:0] idx);
		int p;
		p = 0;
		while (p < n_ranges && lo_tab[p] <= idx)
			p++;
		return p;
	endfunction

	function status_t mark(bit [31:0] idx, bit used);
		int p;
		int q;
		bit hit;
		bit lft;
		bit rgt;
		p = first_above(idx);
		hit = (p > 0) && (hi_tab[p-1] >= idx);
		if (used) begin
			if (hit)
				return ST_OK;
			lft = (p > 0) && (hi_tab[p-1] + 32'd1 == idx);
			rgt = (p < n_ranges) && (idx + 32'd1 == lo_tab[p]);
			if (lft && rgt) begin
				hi_tab[p-1] = hi_tab[p];
				remove_at(p);
			end else if (lft) begin
				hi_tab[p-1] = idx;
			end else if (rgt) begin
				lo_tab[p] = idx;
			end else begin
				if (n_ranges >= MAX_RANGES)
					return ST_FULL;
				insert_at(p, idx, idx);
			end
			return ST_OK;
		end
		if (!hit)
			return ST_OK;
		q = p - 1;
		if (lo_tab[q] == idx && hi_tab[q] == idx) begin
			remove_at(q);
		end else if (lo_tab[q] == idx) begin
			lo_tab[q] = idx + 32'd1;
		end else if (hi_tab[q] == idx) begin
			hi_tab[q] = idx - 32'd1;
		end else begin
			if (n_ranges >= MAX_RANGES)
				return ST_FULL;
			insert_at(q + 1, idx + 32'd1, hi_tab[q]);
			hi_tab[q] = idx - 32'd1;
		end
		return ST_OK;
	endfunction

	function void note_input(in_word_t w);
		out_word_t r;
		int p;
		bit [32:0] total;
		r = '0;
		case (op_t'(w.op))
			OP_MARK: r.status = mark(w.index, w.want_used);
			OP_QUERY: begin
				p = first_above(w.index);
				r.matches_res = (((p > 0) && (hi_tab[p-1] >= w.index)) == w.want_used);
			end
			OP_ALLOC: begin
				if (n_ranges == 0) begin
					insert_at(0, 32'd1, 32'd1);
					r.new_index = 32'd1;
				end else if (lo_tab[0] > 32'd1) begin
					lo_tab[0]--;
					r.new_index = lo_tab[0];
				end else if (hi_tab[0] == 32'hFFFF_FFFF) begin
					r.status = ST_NONE;
				end else begin
					hi_tab[0]++;
					r.new_index = hi_tab[0];
					if (n_ranges > 1 && lo_tab[1] == hi_tab[0] + 32'd1) begin
						hi_tab[0] = hi_tab[1];
						remove_at(1);
					end
				end
			end
			default: begin
				total = '0;
				for (int i = 0; i < n_ranges; i++)
					total += {1'b0, hi_tab[i] - lo_tab[i]} + 33'd1;
				r.index_count = w.want_used ? total : (33'h1_0000_0000 - total);
			end
		endcase
		pending.insert(pending.size(), r);
	endfunction

	function void check_result(out_word_t got);
		out_word_t e;
		checked++;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result word %h", got);
			return;
		end
		e = pending.pop_front();
		if (got.new_index !== e.new_index || got.matches_res !== e.matches_res ||
		    got.index_count !== e.index_count || got.status !== e.status) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: exp idx=%h m=%b cnt=%h st=%0d got idx=%h m=%b cnt=%h st=%0d",
					e.new_index, e.matches_res, e.index_count, e.status,
					got.new_index, got.matches_res, got.index_count, got.status);
		end
	endfunction
endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	out_word_t out_data;

	range_scoreboard sb;
	int idle_cycles = 0;
	int n_sent = 0;
	bit hold_out = 0;
	bit stall_mode = 1;

	localparam int WATCHDOG = 20000;

	index_range_allocator dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_input(in_data);
			if (out_valid && !out_stall)
				sb.check_result(out_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("watchdog expired");
				$display("index_range_allocator test failed");
				$finish;
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (hold_out)
			out_stall <= 1'b1;
		else if (stall_mode)
			out_stall <= ($urandom_range(0, 3) == 0);
		else
			out_stall <= 1'b0;
	end

	task automatic send_word(input op_t op, input bit [31:0] idx, input bit want);
		in_word_t w;
		w.op = op;
		w.index = idx;
		w.want_used = want;
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_sent++;
	endtask

	task automatic pause(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic bit [31:0] pick_index();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 3);
			1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			2: return $urandom;
			default: return $urandom_range(0, 200);
		endcase
	endfunction

	task automatic random_word();
		int k;
		k = $urandom_range(0, 9);
		if (k < 5)
			send_word(OP_MARK, pick_index(), $urandom_range(0, 2) != 0);
		else if (k < 7)
			send_word(OP_QUERY, pick_index(), 1'($urandom_range(0, 1)));
		else if (k < 9)
			send_word(OP_ALLOC, $urandom, 1'($urandom_range(0, 1)));
		else
			send_word(OP_COUNT, $urandom, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, splits
		send_word(OP_COUNT, 32'd0, 1'b1);
		send_word(OP_COUNT, 32'd0, 1'b0);
		send_word(OP_ALLOC, 32'd0, 1'b0);
		send_word(OP_ALLOC, 32'hFFFF_FFFF, 1'b1);
		send_word(OP_MARK, 32'd10, 1'b1);
		send_word(OP_MARK, 32'd10, 1'b1);
		send_word(OP_MARK, 32'd4, 1'b0);
		send_word(OP_MARK, 32'd3, 1'b1);
		send_word(OP_ALLOC, 32'd0, 1'b0);
		send_word(OP_MARK, 32'd2, 1'b0);
		send_word(OP_MARK, 32'd9, 1'b1);
		send_word(OP_MARK, 32'd11, 1'b1);
		send_word(OP_MARK, 32'd10, 1'b0);
		send_word(OP_QUERY, 32'd10, 1'b0);
		send_word(OP_QUERY, 32'd11, 1'b1);
		send_word(OP_MARK, 32'd0, 1'b1);
		send_word(OP_MARK, 32'hFFFF_FFFF, 1'b1);
		send_word(OP_QUERY, 32'hFFFF_FFFF, 1'b0);
		send_word(OP_COUNT, 32'd0, 1'b0);
		drain();
		// top of the domain
		for (int i = 0; i < 3; i++)
			send_word(OP_MARK, 32'hFFFF_FFFE - i, 1'b1);
		drain();

		// fill the table until it overflows, with the output held off
		fork
			begin
				hold_out = 1;
				repeat (300) @(posedge clk);
				hold_out = 0;
			end
			for (int i = 0; i < 70; i++)
				send_word(OP_MARK, 32'd1000 + 2 * i, 1'b1);
		join
		send_word(OP_MARK, 32'd1001, 1'b0);
		send_word(OP_MARK, 32'd1003, 1'b0);
		for (int i = 0; i < 5; i++)
			send_word(OP_MARK, 32'd1002, i[0]);
		send_word(OP_COUNT, 32'd0, 1'b1);
		drain();
		for (int i = 0; i < 70; i++)
			send_word(OP_MARK, 32'd1000 + 2 * i, 1'b0);
		drain();

		// random bursts
		while (n_sent < 450) begin
			stall_mode = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(1, 20))
				random_word();
			if ($urandom_range(0, 1))
				pause($urandom_range(1, 12));
			if ($urandom_range(0, 15) == 0)
				drain();
		end
		send_word(OP_MARK, 32'd0, 1'b1);
		drain();

		drain();
		repeat (400) @(posedge clk);
		$display("sent %0d words, checked %0d results, table overflow and stalls covered",
			n_sent, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("index_range_allocator test passed");
		else
			$display("index_range_allocator test failed");
		$finish;
	end
endmodule

FILE: index_range_allocator.f
sv/ira_pkg.sv
sv/index_range_allocator.sv
tb/sv/index_range_allocator_test.sv
